// ===== design/i2cm_pkg.sv =====
package i2cm_pkg;

  // register map, one 32-bit word per register
  localparam int unsigned REG_ACK_TIMEOUT = 0;
  localparam int unsigned REG_PHASE_TICKS = 1;
  localparam int unsigned CFG_ADDR_W      = 3;
  localparam int unsigned CFG_DATA_W      = 32;

  localparam logic [9:0] ACK_TIMEOUT_RST = 10'd250;
  localparam logic [7:0] PHASE_TICKS_RST = 8'd1;

  localparam logic [1:0] KIND_REG_WRITE   = 2'd0;
  localparam logic [1:0] KIND_REG_READ    = 2'd1;
  localparam logic [1:0] KIND_DIRECT_READ = 2'd2;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_BUS_BUSY    = 2'd1;
  localparam logic [1:0] STATUS_ACK_TIMEOUT = 2'd2;

  localparam logic REQ_TICK    = 1'b0;
  localparam logic REQ_COMMAND = 1'b1;

  localparam logic [7:0] READ_BIT = 8'h01;

  typedef enum logic [3:0] {
    ST_IDLE       = 4'd0,
    ST_START      = 4'd1,
    ST_SEND_ADDRW = 4'd2,
    ST_ACK_ADDRW  = 4'd3,
    ST_SEND_REG   = 4'd4,
    ST_ACK_REG    = 4'd5,
    ST_SEND_DATA  = 4'd6,
    ST_ACK_DATA   = 4'd7,
    ST_RESTART    = 4'd8,
    ST_SEND_ADDRR = 4'd9,
    ST_ACK_ADDRR  = 4'd10,
    ST_READ       = 4'd11,
    ST_MACK       = 4'd12,
    ST_STOP_OK    = 4'd13,
    ST_STOP_FAIL  = 4'd14
  } seq_state_t;

  typedef struct packed {
    logic [9:0] ack_timeout;
    logic [7:0] phase_ticks;
  } cfg_t;

  typedef struct packed {
    logic       req_type;
    logic [1:0] txn_kind;
    logic [7:0] slave_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic       restart;
    logic [7:0] tx_byte;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_low;
    logic       tx_take;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       rx_last;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } result_t;

endpackage

// ===== design/i2cm_cfg.sv =====
module i2cm_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [i2cm_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [i2cm_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready,
  output i2cm_pkg::cfg_t                     cfg
);

  logic [9:0] ack_timeout_r;
  logic [7:0] phase_ticks_r;
  logic       wr_en;
  logic       reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  // word index, byte offset bits ignored
  assign reg_sel    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r <= i2cm_pkg::ACK_TIMEOUT_RST;
      phase_ticks_r <= i2cm_pkg::PHASE_TICKS_RST;
    end else if (wr_en) begin
      if (reg_sel == 1'(i2cm_pkg::REG_PHASE_TICKS)) begin
        phase_ticks_r <= cfg_pwdata[7:0];
      end else begin
        ack_timeout_r <= cfg_pwdata[9:0];
      end
    end
  end

  always_comb begin
    if (reg_sel == 1'(i2cm_pkg::REG_PHASE_TICKS)) begin
      cfg_prdata = {24'd0, phase_ticks_r};
    end else begin
      cfg_prdata = {22'd0, ack_timeout_r};
    end
  end

  assign cfg.ack_timeout = ack_timeout_r;
  assign cfg.phase_ticks = phase_ticks_r;

endmodule

// ===== design/i2cm_seq.sv =====
module i2cm_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  i2cm_pkg::item_t     item,
  input  i2cm_pkg::cfg_t      cfg,
  output i2cm_pkg::result_t   res
);

  i2cm_pkg::seq_state_t state_r, state_nxt;
  logic [7:0] phase_r, phase_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] left_r, left_nxt;
  logic [9:0] wait_r, wait_nxt;
  logic [7:0] h_addr_r, h_addr_nxt;
  logic [7:0] h_reg_r, h_reg_nxt;
  logic       h_rst_r, h_rst_nxt;
  logic [1:0] h_kind_r, h_kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= i2cm_pkg::ST_IDLE;
      phase_r <= '0;
      bit_r   <= '0;
      left_r  <= '0;
      wait_r  <= '0;
    end else if (step_en) begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      left_r  <= left_nxt;
      wait_r  <= wait_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      shift_r  <= shift_nxt;
      h_addr_r <= h_addr_nxt;
      h_reg_r  <= h_reg_nxt;
      h_rst_r  <= h_rst_nxt;
      h_kind_r <= h_kind_nxt;
    end
  end

  always_comb begin
    logic [7:0] pt;
    logic [8:0] pc_inc;
    logic       hd;
    logic [3:0] sub;
    logic [7:0] sr_in;

    state_nxt  = state_r;
    phase_nxt  = phase_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    left_nxt   = left_r;
    wait_nxt   = wait_r;
    h_addr_nxt = h_addr_r;
    h_reg_nxt  = h_reg_r;
    h_rst_nxt  = h_rst_r;
    h_kind_nxt = h_kind_r;
    res        = '0;
    res.scl    = 1'b1;

    // command taken only while idle
    if (state_r == i2cm_pkg::ST_IDLE && item.req_type == i2cm_pkg::REQ_COMMAND &&
        item.txn_kind <= i2cm_pkg::KIND_DIRECT_READ) begin
      h_addr_nxt = item.slave_addr;
      h_reg_nxt  = item.reg_addr;
      h_rst_nxt  = item.restart;
      h_kind_nxt = item.txn_kind;
      if (item.txn_kind == i2cm_pkg::KIND_REG_WRITE || item.byte_count != 8'd0) begin
        left_nxt = item.byte_count;
      end else begin
        left_nxt = 8'd1;
      end
      shift_nxt = '0;
      state_nxt = i2cm_pkg::ST_START;
      bit_nxt   = 4'd1;
      phase_nxt = '0;
      wait_nxt  = '0;
    end

    // half phase counter, zero phase_ticks acts as one
    pt     = (cfg.phase_ticks != 8'd0) ? cfg.phase_ticks : 8'd1;
    pc_inc = {1'b0, phase_nxt} + 9'd1;
    hd     = (pc_inc >= {1'b0, pt});
    sub    = bit_nxt;
    sr_in  = {shift_nxt[6:0], item.sda_in};

    if (state_nxt != i2cm_pkg::ST_IDLE) begin
      res.busy_res = 1'b1;
      case (state_nxt)
        i2cm_pkg::ST_START, i2cm_pkg::ST_RESTART: begin
          if (sub < 4'd1) begin
            sub = (state_nxt == i2cm_pkg::ST_RESTART) ? 4'd0 : 4'd1;
          end
          if (sub > 4'd2) begin
            sub = 4'd2;
          end
          res.scl     = (sub >= 4'd1);
          res.sda_low = (sub == 4'd2);
          phase_nxt   = hd ? 8'd0 : pc_inc[7:0];
          if (hd) begin
            if (sub == 4'd1 && state_nxt == i2cm_pkg::ST_START && !item.sda_in) begin
              res.done_res = 1'b1;
              res.status   = i2cm_pkg::STATUS_BUS_BUSY;
              state_nxt    = i2cm_pkg::ST_IDLE;
              bit_nxt      = '0;
              wait_nxt     = '0;
            end else if (sub < 4'd2) begin
              bit_nxt = sub + 4'd1;
            end else begin
              if (state_nxt == i2cm_pkg::ST_START &&
                  h_kind_nxt != i2cm_pkg::KIND_DIRECT_READ) begin
                shift_nxt = h_addr_nxt;
                state_nxt = i2cm_pkg::ST_SEND_ADDRW;
              end else begin
                shift_nxt = h_addr_nxt | i2cm_pkg::READ_BIT;
                state_nxt = i2cm_pkg::ST_SEND_ADDRR;
              end
              bit_nxt  = '0;
              wait_nxt = '0;
            end
          end
        end
        i2cm_pkg::ST_SEND_ADDRW, i2cm_pkg::ST_SEND_REG,
        i2cm_pkg::ST_SEND_DATA, i2cm_pkg::ST_SEND_ADDRR: begin
          res.scl     = sub[0];
          res.sda_low = ~shift_nxt[3'd7 - sub[3:1]];
          phase_nxt   = hd ? 8'd0 : pc_inc[7:0];
          if (hd) begin
            if (sub == 4'd15) begin
              case (state_nxt)
                i2cm_pkg::ST_SEND_ADDRW: state_nxt = i2cm_pkg::ST_ACK_ADDRW;
                i2cm_pkg::ST_SEND_REG:   state_nxt = i2cm_pkg::ST_ACK_REG;
                i2cm_pkg::ST_SEND_DATA:  state_nxt = i2cm_pkg::ST_ACK_DATA;
                default:                 state_nxt = i2cm_pkg::ST_ACK_ADDRR;
              endcase
              bit_nxt  = '0;
              wait_nxt = '0;
            end else begin
              bit_nxt = sub + 4'd1;
            end
          end
        end
        i2cm_pkg::ST_ACK_ADDRW, i2cm_pkg::ST_ACK_REG,
        i2cm_pkg::ST_ACK_DATA, i2cm_pkg::ST_ACK_ADDRR: begin
          if (sub == 4'd0) begin
            // low half before the acknowledge clock
            res.scl   = 1'b0;
            phase_nxt = hd ? 8'd0 : pc_inc[7:0];
            if (hd) begin
              bit_nxt = 4'd1;
            end
          end else if (item.sda_in) begin
            if (wait_nxt >= cfg.ack_timeout) begin
              state_nxt = i2cm_pkg::ST_STOP_FAIL;
              bit_nxt   = '0;
              phase_nxt = '0;
              wait_nxt  = '0;
            end else begin
              wait_nxt = wait_nxt + 10'd1;
            end
          end else begin
            bit_nxt   = '0;
            phase_nxt = '0;
            wait_nxt  = '0;
            if (state_nxt == i2cm_pkg::ST_ACK_ADDRW) begin
              shift_nxt = h_reg_nxt;
              state_nxt = i2cm_pkg::ST_SEND_REG;
            end else if (state_nxt == i2cm_pkg::ST_ACK_ADDRR) begin
              shift_nxt = '0;
              state_nxt = i2cm_pkg::ST_READ;
            end else if (state_nxt == i2cm_pkg::ST_ACK_REG &&
                         h_kind_nxt != i2cm_pkg::KIND_REG_WRITE) begin
              if (h_rst_nxt) begin
                state_nxt = i2cm_pkg::ST_RESTART;
              end else begin
                shift_nxt = h_addr_nxt | i2cm_pkg::READ_BIT;
                state_nxt = i2cm_pkg::ST_SEND_ADDRR;
              end
            end else begin
              if (state_nxt == i2cm_pkg::ST_ACK_DATA && left_nxt != 8'd0) begin
                left_nxt = left_nxt - 8'd1;
              end
              if (left_nxt != 8'd0) begin
                res.tx_take = 1'b1;
                shift_nxt   = item.tx_byte;
                state_nxt   = i2cm_pkg::ST_SEND_DATA;
              end else begin
                state_nxt = i2cm_pkg::ST_STOP_OK;
              end
            end
          end
        end
        i2cm_pkg::ST_READ: begin
          res.scl   = sub[0];
          phase_nxt = hd ? 8'd0 : pc_inc[7:0];
          if (hd) begin
            // sample on the high half
            if (sub[0]) begin
              shift_nxt = sr_in;
            end
            if (sub == 4'd15) begin
              res.rx_byte  = shift_nxt;
              res.rx_valid = 1'b1;
              res.rx_last  = (left_nxt <= 8'd1);
              state_nxt    = i2cm_pkg::ST_MACK;
              bit_nxt      = '0;
              wait_nxt     = '0;
            end else begin
              bit_nxt = sub + 4'd1;
            end
          end
        end
        i2cm_pkg::ST_MACK: begin
          res.scl     = (sub >= 4'd1);
          res.sda_low = (left_nxt > 8'd1);
          phase_nxt   = hd ? 8'd0 : pc_inc[7:0];
          if (hd) begin
            if (sub == 4'd0) begin
              bit_nxt = 4'd1;
            end else begin
              bit_nxt  = '0;
              wait_nxt = '0;
              if (left_nxt > 8'd1) begin
                left_nxt  = left_nxt - 8'd1;
                shift_nxt = '0;
                state_nxt = i2cm_pkg::ST_READ;
              end else begin
                state_nxt = i2cm_pkg::ST_STOP_OK;
              end
            end
          end
        end
        i2cm_pkg::ST_STOP_OK, i2cm_pkg::ST_STOP_FAIL: begin
          if (sub > 4'd2) begin
            sub = 4'd2;
          end
          res.scl     = (sub >= 4'd1);
          res.sda_low = (sub <= 4'd1);
          phase_nxt   = hd ? 8'd0 : pc_inc[7:0];
          if (hd) begin
            if (sub < 4'd2) begin
              bit_nxt = sub + 4'd1;
            end else begin
              res.done_res = 1'b1;
              res.status   = (state_nxt == i2cm_pkg::ST_STOP_FAIL) ?
                             i2cm_pkg::STATUS_ACK_TIMEOUT : i2cm_pkg::STATUS_OK;
              state_nxt    = i2cm_pkg::ST_IDLE;
              bit_nxt      = '0;
              wait_nxt     = '0;
            end
          end
        end
        default: begin
          state_nxt = i2cm_pkg::ST_IDLE;
          bit_nxt   = '0;
          phase_nxt = '0;
          wait_nxt  = '0;
        end
      endcase
    end
  end

endmodule

// ===== design/i2cm_obuf.sv =====
module i2cm_obuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  i2cm_pkg::result_t  in_res,
  output logic               out_valid,
  input  logic               out_ready,
  output i2cm_pkg::result_t  out_res
);

  logic              out_valid_r;
  logic              skid_valid_r;
  i2cm_pkg::result_t out_data_r;
  i2cm_pkg::result_t skid_data_r;
  logic              in_fire;
  logic              out_free;

  assign in_ready  = ~skid_valid_r;
  assign in_fire   = in_valid & in_ready;
  assign out_free  = out_ready | ~out_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_free) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ready) begin
        out_data_r <= skid_data_r;
      end
    end else if (in_fire) begin
      if (out_free) begin
        out_data_r <= in_res;
      end else begin
        skid_data_r <= in_res;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid beat held without a head beat");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && out_valid_r && !out_ready) |=> skid_valid_r)
    else $error("beat accepted under stall was not parked");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_ready) |=> (!skid_valid_r && out_valid_r))
    else $error("skid beat not moved to the head");
`endif

endmodule

// ===== design/i2c_master_register_access.sv =====
// I2C master for register write, register read and direct read.
// in channel: one beat per bus tick. in_tuser[0] marks a command beat; a command
// is taken only while no transaction runs, otherwise the beat is a plain tick.
// in_tdata carries the command fields, the next write byte and the sampled SDA.
// out channel: exactly one beat per in beat, carrying the SCL level, the SDA
// drive, tx byte consumption, received bytes (tlast on the NACKed last byte),
// busy, done and completion status.
// each taken in beat's result is registered in the output stage (or its skid entry).
// throughput: one beat per cycle while in_tready is high; the whole tick step is one pass of logic
// from the sequencer state to the result register.
// each SCL half phase lasts phase_ticks ticks; acknowledge polling gives up
// at the first high SDA sample once ack_timeout high samples have been counted.
// cfg port: ack_timeout at 0x0, phase_ticks at 0x4; the user must write them only
// while idle, which the block does not enforce. reset: sequencer idle, SCL high,
// SDA released, registers at 250 and 1, no result pending.
// stall: a two-entry output stage keeps in_tready high while one result
// waits; with a second result parked, in_tready drops until out_tready rises.
module i2c_master_register_access (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // slave_addr, reg_addr, byte_count, restart, tx_byte, sda_in, zero pad
  input  logic [39:0]                        in_tdata,
  // req_type, txn_kind
  input  logic [2:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // scl, sda_low, tx_take, rx_byte, rx_valid, busy_res, done_res, status
  output logic [15:0]                        out_tdata,
  output logic                               out_tlast,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [i2cm_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [i2cm_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  i2cm_pkg::cfg_t    cfg;
  i2cm_pkg::item_t   item;
  i2cm_pkg::result_t step_res;
  i2cm_pkg::result_t out_res;
  logic              in_fire;

  assign in_fire = in_tvalid & in_tready;

  assign item.req_type   = in_tuser[0];
  assign item.txn_kind   = in_tuser[2:1];
  assign item.slave_addr = in_tdata[7:0];
  assign item.reg_addr   = in_tdata[15:8];
  assign item.byte_count = in_tdata[23:16];
  assign item.restart    = in_tdata[24];
  assign item.tx_byte    = in_tdata[32:25];
  assign item.sda_in     = in_tdata[33];

  i2cm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  i2cm_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_fire),
    .item    (item),
    .cfg     (cfg),
    .res     (step_res)
  );

  i2cm_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_res    (step_res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {out_res.status, out_res.done_res, out_res.busy_res,
                      out_res.rx_valid, out_res.rx_byte, out_res.tx_take,
                      out_res.sda_low, out_res.scl};
  assign out_tlast = out_res.rx_last;

endmodule

// ===== tb/sv/i2c_master_register_access_tb.sv =====
module i2c_master_register_access_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum int {SLV_ACK, SLV_BUS_HELD, SLV_NO_ACK, SLV_RANDOM} slave_mode_t;

  // tracks the sequencer per tick and holds the bus levels it predicts
  class bus_tick_board_t;
    logic [9:0]           ack_timeout;
    logic [7:0]           phase_ticks;
    i2cm_pkg::seq_state_t seq;
    logic [7:0]           phase_cnt;
    logic [3:0]           bit_idx;
    logic [7:0]           shifter;
    logic [7:0]           bytes_left;
    logic [9:0]           wait_cnt;
    logic [7:0]           held_addr;
    logic [7:0]           held_reg;
    logic                 held_restart;
    logic [1:0]           held_kind;
    i2cm_pkg::result_t    line_states_q[$];
    int                   errors;

    function new();
      ack_timeout  = i2cm_pkg::ACK_TIMEOUT_RST;
      phase_ticks  = i2cm_pkg::PHASE_TICKS_RST;
      seq          = i2cm_pkg::ST_IDLE;
      phase_cnt    = '0;
      bit_idx      = '0;
      shifter      = '0;
      bytes_left   = '0;
      wait_cnt     = '0;
      held_addr    = '0;
      held_reg     = '0;
      held_restart = 1'b0;
      held_kind    = '0;
      errors       = 0;
    endfunction

    function void set_reg(int unsigned idx, logic [31:0] value);
      if (idx == i2cm_pkg::REG_ACK_TIMEOUT) begin
        ack_timeout = value[9:0];
      end else if (idx == i2cm_pkg::REG_PHASE_TICKS) begin
        phase_ticks = value[7:0];
      end
    endfunction

    function bit half_done();
      int pt;
      pt = (phase_ticks == 0) ? 1 : int'(phase_ticks);
      if (int'(phase_cnt) + 1 >= pt) begin
        phase_cnt = '0;
        return 1'b1;
      end
      phase_cnt = phase_cnt + 1'b1;
      return 1'b0;
    endfunction

    function void go(i2cm_pkg::seq_state_t st, logic [3:0] sub);
      seq       = st;
      bit_idx   = sub;
      phase_cnt = '0;
      wait_cnt  = '0;
    endfunction

    function void note_tick(i2cm_pkg::item_t it);
      i2cm_pkg::result_t r;
      logic [3:0] sub;
      r = '0;
      r.scl = 1'b1;
      if (seq == i2cm_pkg::ST_IDLE && it.req_type == i2cm_pkg::REQ_COMMAND &&
          it.txn_kind <= i2cm_pkg::KIND_DIRECT_READ) begin
        held_addr    = it.slave_addr;
        held_reg     = it.reg_addr;
        held_restart = it.restart;
        held_kind    = it.txn_kind;
        if (it.txn_kind == i2cm_pkg::KIND_REG_WRITE) begin
          bytes_left = it.byte_count;
        end else begin
          // a read of zero bytes still fetches one
          bytes_left = (it.byte_count == 0) ? 8'd1 : it.byte_count;
        end
        shifter = '0;
        go(i2cm_pkg::ST_START, 4'd1);
      end
      if (seq != i2cm_pkg::ST_IDLE) begin
        r.busy_res = 1'b1;
        sub = bit_idx;
        case (seq)
          i2cm_pkg::ST_START, i2cm_pkg::ST_RESTART: begin
            if (sub < 1) sub = (seq == i2cm_pkg::ST_RESTART) ? 4'd0 : 4'd1;
            if (sub > 2) sub = 4'd2;
            r.scl     = (sub >= 1);
            r.sda_low = (sub == 2);
            if (half_done()) begin
              if (sub == 1 && seq == i2cm_pkg::ST_START && it.sda_in == 1'b0) begin
                // line held low by someone else, give up without a stop
                r.done_res = 1'b1;
                r.status   = i2cm_pkg::STATUS_BUS_BUSY;
                go(i2cm_pkg::ST_IDLE, 4'd0);
              end else if (sub < 2) begin
                bit_idx = sub + 1'b1;
              end else if (seq == i2cm_pkg::ST_START &&
                           held_kind != i2cm_pkg::KIND_DIRECT_READ) begin
                shifter = held_addr;
                go(i2cm_pkg::ST_SEND_ADDRW, 4'd0);
              end else begin
                shifter = held_addr | i2cm_pkg::READ_BIT;
                go(i2cm_pkg::ST_SEND_ADDRR, 4'd0);
              end
            end
          end
          i2cm_pkg::ST_SEND_ADDRW, i2cm_pkg::ST_SEND_REG,
          i2cm_pkg::ST_SEND_DATA, i2cm_pkg::ST_SEND_ADDRR: begin
            r.scl     = sub[0];
            r.sda_low = !shifter[7 - sub[3:1]];
            if (half_done()) begin
              if (sub == 4'd15) begin
                go(i2cm_pkg::seq_state_t'(seq + 1), 4'd0);
              end else begin
                bit_idx = sub + 1'b1;
              end
            end
          end
          i2cm_pkg::ST_ACK_ADDRW, i2cm_pkg::ST_ACK_REG,
          i2cm_pkg::ST_ACK_DATA, i2cm_pkg::ST_ACK_ADDRR: begin
            if (sub == 0) begin
              r.scl = 1'b0;
              if (half_done()) bit_idx = 4'd1;
            end else if (it.sda_in) begin
              if (wait_cnt >= ack_timeout) begin
                go(i2cm_pkg::ST_STOP_FAIL, 4'd0);
              end else begin
                wait_cnt = wait_cnt + 1'b1;
              end
            end else if (seq == i2cm_pkg::ST_ACK_ADDRW) begin
              shifter = held_reg;
              go(i2cm_pkg::ST_SEND_REG, 4'd0);
            end else if (seq == i2cm_pkg::ST_ACK_ADDRR) begin
              shifter = '0;
              go(i2cm_pkg::ST_READ, 4'd0);
            end else if (seq == i2cm_pkg::ST_ACK_REG &&
                         held_kind != i2cm_pkg::KIND_REG_WRITE) begin
              if (held_restart) begin
                go(i2cm_pkg::ST_RESTART, 4'd0);
              end else begin
                shifter = held_addr | i2cm_pkg::READ_BIT;
                go(i2cm_pkg::ST_SEND_ADDRR, 4'd0);
              end
            end else begin
              if (seq == i2cm_pkg::ST_ACK_DATA && bytes_left > 0)
                bytes_left = bytes_left - 1'b1;
              if (bytes_left > 0) begin
                r.tx_take = 1'b1;
                shifter   = it.tx_byte;
                go(i2cm_pkg::ST_SEND_DATA, 4'd0);
              end else begin
                go(i2cm_pkg::ST_STOP_OK, 4'd0);
              end
            end
          end
          i2cm_pkg::ST_READ: begin
            r.scl = sub[0];
            if (half_done()) begin
              if (sub[0]) shifter = {shifter[6:0], it.sda_in};
              if (sub == 4'd15) begin
                r.rx_byte  = shifter;
                r.rx_valid = 1'b1;
                r.rx_last  = (bytes_left <= 1);
                go(i2cm_pkg::ST_MACK, 4'd0);
              end else begin
                bit_idx = sub + 1'b1;
              end
            end
          end
          i2cm_pkg::ST_MACK: begin
            r.scl     = (sub >= 1);
            r.sda_low = (bytes_left > 1);
            if (half_done()) begin
              if (sub == 0) begin
                bit_idx = 4'd1;
              end else if (bytes_left > 1) begin
                bytes_left = bytes_left - 1'b1;
                shifter    = '0;
                go(i2cm_pkg::ST_READ, 4'd0);
              end else begin
                go(i2cm_pkg::ST_STOP_OK, 4'd0);
              end
            end
          end
          i2cm_pkg::ST_STOP_OK, i2cm_pkg::ST_STOP_FAIL: begin
            if (sub > 2) sub = 4'd2;
            r.scl     = (sub >= 1);
            r.sda_low = (sub <= 1);
            if (half_done()) begin
              if (sub < 2) begin
                bit_idx = sub + 1'b1;
              end else begin
                r.done_res = 1'b1;
                r.status   = (seq == i2cm_pkg::ST_STOP_FAIL) ?
                             i2cm_pkg::STATUS_ACK_TIMEOUT : i2cm_pkg::STATUS_OK;
                go(i2cm_pkg::ST_IDLE, 4'd0);
              end
            end
          end
          default: go(i2cm_pkg::ST_IDLE, 4'd0);
        endcase
      end
      line_states_q.push_back(r);
    endfunction

    function void cmp_field(string nm, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, nm, want_v, got_v);
      end
    endfunction

    function void check_beat(i2cm_pkg::result_t got);
      i2cm_pkg::result_t want;
      if (line_states_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with none pending, expected none actual %h", $time, got);
        return;
      end
      want = line_states_q.pop_front();
      cmp_field("scl", 32'(want.scl), 32'(got.scl));
      cmp_field("sda_low", 32'(want.sda_low), 32'(got.sda_low));
      cmp_field("tx_take", 32'(want.tx_take), 32'(got.tx_take));
      cmp_field("rx_byte", 32'(want.rx_byte), 32'(got.rx_byte));
      cmp_field("rx_valid", 32'(want.rx_valid), 32'(got.rx_valid));
      cmp_field("rx_last", 32'(want.rx_last), 32'(got.rx_last));
      cmp_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
      cmp_field("done_res", 32'(want.done_res), 32'(got.done_res));
      cmp_field("status", 32'(want.status), 32'(got.status));
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [39:0]                     in_tdata = '0;
  logic [2:0]                      in_tuser = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [15:0]                     out_tdata;
  logic                            out_tlast;
  logic                            cfg_psel = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite = 1'b0;
  logic [i2cm_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  bus_tick_board_t board = new();
  idle_mode_t      idle_mode = IDLE_NONE;
  slave_mode_t     slave_mode = SLV_ACK;
  bit              ack_mute = 1'b0;
  bit              large_ok = 1'b0;
  int unsigned     cycle_cnt = 0;

  i2c_master_register_access uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic bit sender_gap();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 82;
      IDLE_BOTH:   return $urandom_range(0, 99) < 14;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(0, 99) < 82;
      IDLE_BOTH:     return $urandom_range(0, 99) < 14;
      default:       return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin : result_sink
    i2cm_pkg::result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.scl      = out_tdata[0];
      got.sda_low  = out_tdata[1];
      got.tx_take  = out_tdata[2];
      got.rx_byte  = out_tdata[10:3];
      got.rx_valid = out_tdata[11];
      got.busy_res = out_tdata[12];
      got.done_res = out_tdata[13];
      got.status   = out_tdata[15:14];
      got.rx_last  = out_tlast;
      board.check_beat(got);
    end
    out_tready <= !receiver_stall();
  end

  function automatic bit in_ack_state();
    return board.seq inside {i2cm_pkg::ST_ACK_ADDRW, i2cm_pkg::ST_ACK_REG,
                             i2cm_pkg::ST_ACK_DATA, i2cm_pkg::ST_ACK_ADDRR};
  endfunction

  // what an attached slave would put on sda for the coming tick
  function automatic logic slave_sda();
    if (slave_mode == SLV_BUS_HELD) return 1'b0;
    if (slave_mode == SLV_NO_ACK) return 1'b1;
    if (in_ack_state() && board.bit_idx != 0) begin
      if (slave_mode == SLV_ACK) return 1'b0;
      if (ack_mute) return 1'b1;
      return $urandom_range(0, 3) == 0;
    end
    if (board.seq == i2cm_pkg::ST_IDLE ||
        (board.seq == i2cm_pkg::ST_START && board.bit_idx <= 1)) begin
      if (slave_mode == SLV_ACK) return 1'b1;
      return $urandom_range(0, 19) != 0;
    end
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic i2cm_pkg::item_t make_tick(bit cmd_ok);
    i2cm_pkg::item_t it;
    int pick;
    it.req_type   = 1'($urandom_range(0, 1));
    it.txn_kind   = 2'($urandom_range(0, 3));
    it.slave_addr = 8'($urandom);
    it.reg_addr   = 8'($urandom);
    it.byte_count = 8'($urandom);
    it.restart    = 1'($urandom_range(0, 1));
    it.tx_byte    = 8'($urandom);
    // a silent slave stays silent for the whole acknowledge slot
    if (!in_ack_state()) ack_mute = ($urandom_range(0, 24) == 0);
    it.sda_in = slave_sda();
    if (board.seq == i2cm_pkg::ST_IDLE) begin
      pick = $urandom_range(0, 99);
      if (!cmd_ok || pick >= 80) begin
        it.req_type = i2cm_pkg::REQ_TICK;
      end else begin
        it.req_type = i2cm_pkg::REQ_COMMAND;
        if (pick < 72) begin
          it.txn_kind = 2'($urandom_range(i2cm_pkg::KIND_REG_WRITE,
                                          i2cm_pkg::KIND_DIRECT_READ));
        end else begin
          it.txn_kind = KIND_UNUSED;
        end
        pick = $urandom_range(0, 99);
        if (large_ok && pick < 2) begin
          it.byte_count = 8'($urandom_range(16, 31));
        end else if (pick < 87) begin
          it.byte_count = 8'($urandom_range(0, 3));
        end else begin
          it.byte_count = 8'($urandom_range(4, 15));
        end
      end
    end
    return it;
  endfunction

  task automatic push_tick(input i2cm_pkg::item_t it);
    while (sender_gap()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, it.sda_in, it.tx_byte, it.restart, it.byte_count,
                  it.reg_addr, it.slave_addr};
    in_tuser  <= {it.txn_kind, it.req_type};
    do @(posedge clk); while (!in_tready);
    board.note_tick(it);
  endtask

  // plain ticks until the sequencer is idle, then let every beat drain out
  task automatic drain();
    while (board.seq != i2cm_pkg::ST_IDLE) push_tick(make_tick(1'b0));
    in_tvalid <= 1'b0;
    while (board.line_states_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic run_txn(input logic [1:0] kind, input logic [7:0] addr, input logic [7:0] reg_a,
                         input logic [7:0] cnt, input logic rs, input slave_mode_t sm);
    i2cm_pkg::item_t it;
    slave_mode    = sm;
    it            = make_tick(1'b0);
    it.req_type   = i2cm_pkg::REQ_COMMAND;
    it.txn_kind   = kind;
    it.slave_addr = addr;
    it.reg_addr   = reg_a;
    it.byte_count = cnt;
    it.restart    = rs;
    push_tick(it);
    drain();
  endtask

  task automatic run_random(input int n_ticks, input bit big_ok);
    slave_mode = SLV_RANDOM;
    large_ok   = big_ok;
    repeat (n_ticks) push_tick(make_tick(1'b1));
    drain();
  endtask

  task automatic cfg_write(input logic [i2cm_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read(input logic [i2cm_pkg::CFG_ADDR_W-1:0] addr,
                          output logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    data = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [9:0] timeout_v, input logic [7:0] ticks_v);
    logic [31:0] rd;
    cfg_write(i2cm_pkg::CFG_ADDR_W'(i2cm_pkg::REG_ACK_TIMEOUT * 4), {22'd0, timeout_v});
    cfg_write(i2cm_pkg::CFG_ADDR_W'(i2cm_pkg::REG_PHASE_TICKS * 4), {24'd0, ticks_v});
    board.set_reg(i2cm_pkg::REG_ACK_TIMEOUT, {22'd0, timeout_v});
    board.set_reg(i2cm_pkg::REG_PHASE_TICKS, {24'd0, ticks_v});
    cfg_read(i2cm_pkg::CFG_ADDR_W'(i2cm_pkg::REG_ACK_TIMEOUT * 4), rd);
    board.cmp_field("ack_timeout readback", {22'd0, timeout_v}, rd);
    cfg_read(i2cm_pkg::CFG_ADDR_W'(i2cm_pkg::REG_PHASE_TICKS * 4), rd);
    board.cmp_field("phase_ticks readback", {24'd0, ticks_v}, rd);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed transactions at reset settings
    run_txn(i2cm_pkg::KIND_REG_WRITE, 8'hFF, 8'h00, 8'd0, 1'b0, SLV_ACK);
    run_txn(i2cm_pkg::KIND_REG_WRITE, 8'h00, 8'hFF, 8'd1, 1'b1, SLV_ACK);
    run_txn(i2cm_pkg::KIND_REG_READ, 8'hA4, 8'h5A, 8'd0, 1'b1, SLV_ACK);
    run_txn(i2cm_pkg::KIND_REG_READ, 8'h5B, 8'hA5, 8'd2, 1'b0, SLV_ACK);
    run_txn(i2cm_pkg::KIND_DIRECT_READ, 8'hA5, 8'h3C, 8'd3, 1'b1, SLV_ACK);
    run_txn(KIND_UNUSED, 8'h12, 8'h34, 8'd2, 1'b0, SLV_ACK);
    run_txn(i2cm_pkg::KIND_DIRECT_READ, 8'h22, 8'h00, 8'd1, 1'b0, SLV_BUS_HELD);
    run_txn(i2cm_pkg::KIND_REG_WRITE, 8'h50, 8'h10, 8'd2, 1'b0, SLV_NO_ACK);

    idle_mode = IDLE_NONE;
    run_random(150, 1'b1);
    set_config(10'd1, 8'd1);
    idle_mode = IDLE_SENDER;
    run_random(120, 1'b1);
    set_config(10'd1023, 8'd2);
    idle_mode = IDLE_RECEIVER;
    run_random(120, 1'b0);
    set_config(10'd0, 8'd0);
    idle_mode = IDLE_BOTH;
    run_random(120, 1'b1);
    set_config(10'd5, 8'd3);
    idle_mode = IDLE_NONE;
    run_txn(i2cm_pkg::KIND_REG_READ, 8'h51, 8'h11, 8'd1, 1'b1, SLV_NO_ACK);
    run_random(80, 1'b0);
    // slowest bus clock, line held low at start
    set_config(10'd250, 8'd255);
    idle_mode = IDLE_BOTH;
    run_txn(i2cm_pkg::KIND_DIRECT_READ, 8'h3C, 8'h00, 8'd1, 1'b0, SLV_BUS_HELD);
    set_config(10'd250, 8'd1);
    idle_mode = IDLE_SENDER;
    run_random(80, 1'b1);

    repeat (4) @(posedge clk);
    if (board.errors == 0 && board.line_states_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
